### hdl/rbwn_pkg.sv
// package: widths, register indexes and types for the raw black/white normalizer
`timescale 1ns / 1ps
package rbwn_pkg;

  localparam int RawBitsDefault     = 16;
  localparam int OutFracBitsDefault = 16;
  localparam int LevelBits          = 24;
  localparam int BiasBits           = 16;
  localparam int GainBits           = 16;
  localparam int GainFrac           = 14;
  localparam int OutBits            = 20;
  // black with biases: 24-bit unsigned plus two signed 16-bit values
  localparam int BlackBits          = 26;
  // num and den magnitudes, den kept below 2^25
  localparam int MagBits            = 26;
  localparam int DenBits            = 25;
  localparam int OneDn              = 256;

  localparam logic [2:0] RegBlackEe  = 3'd0;
  localparam logic [2:0] RegBlackEo  = 3'd1;
  localparam logic [2:0] RegBlackOe  = 3'd2;
  localparam logic [2:0] RegBlackOo  = 3'd3;
  localparam logic [2:0] RegWhite    = 3'd4;
  localparam logic [2:0] RegResidual = 3'd5;
  localparam logic [2:0] RegGain     = 3'd6;

  typedef struct packed {
    logic                 gain_en;
    logic [GainBits-1:0]  gain;
    logic                 last;
  } side_t;

endpackage

### hdl/raw_black_white_normalize.sv
// top level: raw black/white level normalizer with a chain of divide cells
//
//  channel | dir | fields
//  s_axis  | in  | tdata: raw_sample, row_bias, col_bias, pixel_gain; tuser: row_odd, col_odd
//  m_axis  | out | tdata: normalized, saturated; tlast
//  apb     | in  | seven registers at 4*i
//
// one pixel per clock while the output is not stalled; the divide chain has one cell
// per quotient bit (QBITS = MagBits + OUT_FRAC_BITS)
// the whole pipe advances when the output register is free or taken
// rst clears the valid bits and sets the APB registers to their reset values
`timescale 1ns / 1ps
module raw_black_white_normalize
  import rbwn_pkg::*;
#(
  parameter int RAW_BITS      = RawBitsDefault,
  parameter int OUT_FRAC_BITS = OutFracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_sample[15:0], row_bias[31:16], col_bias[47:32], pixel_gain[63:48]
  input  logic [63:0] s_axis_tdata,
  // row_odd[0], col_odd[1]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // normalized[19:0], saturated[20], zeros above
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QBITS = MagBits + OUT_FRAC_BITS;
  localparam int LAT   = QBITS + 4;

  logic [LevelBits-1:0] black_ee, black_eo, black_oe, black_oo, white;
  logic                 residual_en, gain_en;
  logic [2:0]           reg_idx;
  logic                 adv;
  logic [LAT:0]         vld;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      black_ee <= '0; black_eo <= '0; black_oe <= '0; black_oo <= '0;
      white <= 24'hFFFF00; residual_en <= 1'b0; gain_en <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        RegBlackEe:  black_ee <= pwdata[LevelBits-1:0];
        RegBlackEo:  black_eo <= pwdata[LevelBits-1:0];
        RegBlackOe:  black_oe <= pwdata[LevelBits-1:0];
        RegBlackOo:  black_oo <= pwdata[LevelBits-1:0];
        RegWhite:    white    <= pwdata[LevelBits-1:0];
        RegResidual: residual_en <= pwdata[0];
        RegGain:     gain_en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegBlackEe:  prdata = {8'd0, black_ee};
      RegBlackEo:  prdata = {8'd0, black_eo};
      RegBlackOe:  prdata = {8'd0, black_oe};
      RegBlackOo:  prdata = {8'd0, black_oo};
      RegWhite:    prdata = {8'd0, white};
      RegResidual: prdata = {31'd0, residual_en};
      RegGain:     prdata = {31'd0, gain_en};
      default:     prdata = '0;
    endcase
  end

  // pipe advances unless the output holds an untaken result
  assign adv           = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-1:0], s_axis_tvalid};
  end

  // stage 0: black level
  logic signed [BlackBits-1:0] blk0;
  logic [RAW_BITS-1:0]         raw0;
  side_t                       side0;
  logic [LevelBits-1:0]        phase_lvl;

  always_comb begin
    case (s_axis_tuser)
      2'b00:   phase_lvl = black_ee;
      2'b10:   phase_lvl = black_eo;
      2'b01:   phase_lvl = black_oe;
      default: phase_lvl = black_oo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blk0 <= $signed({2'b00, phase_lvl}) + (residual_en ?
              ($signed({{(BlackBits-BiasBits){s_axis_tdata[31]}}, s_axis_tdata[31:16]})
             + $signed({{(BlackBits-BiasBits){s_axis_tdata[47]}}, s_axis_tdata[47:32]}))
             : $signed({BlackBits{1'b0}}));
      raw0  <= s_axis_tdata[RAW_BITS-1:0];
      side0 <= '{gain_en: gain_en, gain: s_axis_tdata[63:48], last: s_axis_tlast};
    end
  end

  // stage 1: numerator and divisor
  logic signed [BlackBits+1:0] num_s, den_s;
  logic [MagBits-1:0]          mag1;
  logic [DenBits-1:0]          den1;
  logic                        neg1;
  side_t                       side1;

  always_comb begin
    num_s = $signed({{(BlackBits+2-RAW_BITS-8){1'b0}}, raw0, 8'd0})
          - $signed({{2{blk0[BlackBits-1]}}, blk0});
    den_s = $signed({4'd0, white}) - $signed({{2{blk0[BlackBits-1]}}, blk0});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1  <= num_s[BlackBits+1];
      mag1  <= num_s[BlackBits+1] ? MagBits'(-num_s) : MagBits'(num_s);
      den1  <= (den_s < $signed((BlackBits+2)'(OneDn))) ? DenBits'(OneDn) : DenBits'(den_s);
      side1 <= side0;
    end
  end

  // stage 2: rounding offset folded in, (mag<<F + den/2) / den
  logic [QBITS-1:0]   dnum [0:QBITS];
  logic [QBITS-1:0]   dquo [0:QBITS];
  logic [MagBits-1:0] drem [0:QBITS];
  logic [DenBits-1:0] dden [0:QBITS];
  logic               dneg [0:QBITS];
  side_t              dside[0:QBITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      dnum[0]  <= {mag1, {OUT_FRAC_BITS{1'b0}}} + QBITS'(den1 >> 1);
      dquo[0]  <= '0;
      drem[0]  <= '0;
      dden[0]  <= den1;
      dneg[0]  <= neg1;
      dside[0] <= side1;
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    rbwn_div_cell #(.QBITS(QBITS)) u_cell (
      .clk(clk), .en(adv),
      .rem_in(drem[i]), .den_in(dden[i]), .num_in(dnum[i]), .quo_in(dquo[i]),
      .neg_in(dneg[i]), .side_in(dside[i]),
      .rem(drem[i+1]), .den(dden[i+1]), .num(dnum[i+1]), .quo(dquo[i+1]),
      .neg(dneg[i+1]), .side(dside[i+1])
    );
  end

  // gain stage: quotient clipped to 2^34 beforehand, which saturates for any nonzero gain
  localparam int QC = 35;
  logic [QC-1:0]      qc;
  logic [QC+GainBits-1:0] prod;
  logic               negg;
  side_t              sideg;

  always_comb begin
    qc = (|(dquo[QBITS] >> (QC-1))) ? QC'(64'd1 << (QC-1)) : QC'(dquo[QBITS]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod  <= dside[QBITS].gain_en
               ? ((QC+GainBits)'(qc) * (QC+GainBits)'(dside[QBITS].gain)
                  + (QC+GainBits)'(1 << (GainFrac-1))) >> GainFrac
               : (QC+GainBits)'(qc);
      negg  <= dneg[QBITS];
      sideg <= dside[QBITS];
    end
  end

  // output register with saturation
  logic              big;
  logic [OutBits-1:0] outv;
  logic              sat;

  always_comb begin
    if (negg) begin
      big  = prod > (QC+GainBits)'(1 << (OutBits-1));
      outv = big ? OutBits'(1 << (OutBits-1)) : OutBits'(-prod);
    end else begin
      big  = prod > (QC+GainBits)'((1 << (OutBits-1)) - 1);
      outv = big ? OutBits'((1 << (OutBits-1)) - 1) : OutBits'(prod);
    end
    sat = big;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {3'd0, sat, outv};
      m_axis_tlast <= sideg.last;
    end
  end

endmodule

### hdl/rbwn_div_cell.sv
// one restoring divide cell: produces one quotient bit per stage
`timescale 1ns / 1ps
module rbwn_div_cell
  import rbwn_pkg::*;
#(
  parameter int QBITS = 42
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MagBits-1:0]   rem_in,
  input  logic [DenBits-1:0]   den_in,
  input  logic [QBITS-1:0]     num_in,
  input  logic [QBITS-1:0]     quo_in,
  input  logic                 neg_in,
  input  side_t                side_in,
  output logic [MagBits-1:0]   rem,
  output logic [DenBits-1:0]   den,
  output logic [QBITS-1:0]     num,
  output logic [QBITS-1:0]     quo,
  output logic                 neg,
  output side_t                side
);

  logic [MagBits:0] shifted;
  logic [MagBits:0] diff;
  logic             take;

  always_comb begin
    shifted = {rem_in, num_in[QBITS-1]};
    diff    = shifted - {{(MagBits+1-DenBits){1'b0}}, den_in};
    take    = !diff[MagBits];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= take ? diff[MagBits-1:0] : shifted[MagBits-1:0];
      num  <= {num_in[QBITS-2:0], 1'b0};
      quo  <= {quo_in[QBITS-2:0], take};
      den  <= den_in;
      neg  <= neg_in;
      side <= side_in;
    end
  end

endmodule
